// ----- hdl/srr_pkg.sv -----
package srr_pkg;

    localparam int SEQ_W  = 16;
    localparam int DATA_W = 32;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 16;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DUP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd3;

    // register map: word index taken from paddr[2]
    localparam logic REG_TOTAL_ITEMS = 1'b0;
    localparam logic [CNT_W-1:0] TOTAL_ITEMS_RST = 16'd16;

    // frame as queued between front and back
    typedef struct packed {
        logic              beyond;   // seq at or past total_items
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
    } t_frame;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
        logic              last;
        logic              complete;
    } t_result;

endpackage

// ----- hdl/srr_front.sv -----
module srr_front
    import srr_pkg::*;
#(
    parameter int SEQ_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_total,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SEQ_W-1:0]  i_seq,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output t_frame            o_q_frame
);

    localparam int SW = (SEQ_BITS < SEQ_W) ? SEQ_BITS : SEQ_W;
    localparam logic [SEQ_W-1:0] SEQ_MASK = SEQ_W'((32'd1 << SW) - 32'd1);

    t_frame     r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic       push;
    logic       pop;
    logic [SEQ_W-1:0] seq_m;

    assign seq_m     = i_seq & SEQ_MASK;
    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_frame = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= '{beyond: (seq_m >= i_total), seq: seq_m, data: i_data};
        end
    end

endmodule

// ----- hdl/srr_back.sv -----
module srr_back
    import srr_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_total,
    input  logic             i_q_valid,
    output logic             o_q_pop,
    input  t_frame           i_q_frame,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW - 1);

    typedef enum logic {
        S_IDLE,
        S_SLIDE
    } t_state;

    t_state             r_state,  n_state;
    logic [CNT_W-1:0]   r_base,   n_base;
    logic [IW-1:0]      r_bslot,  n_bslot;
    logic [WINDOW-1:0]  r_marks,  n_marks;
    logic               r_valid,  n_valid;
    t_result            r_res,    n_res;

    logic [DATA_W-1:0]  r_mem [WINDOW];
    logic [DATA_W-1:0]  r_rd;
    logic               we;
    logic [IW-1:0]      wslot;

    logic               out_free;
    logic               below;
    logic               in_win;
    logic               accept;
    logic               more;
    logic [SEQ_W-1:0]   off;
    logic [IW:0]        sum;
    logic [IW-1:0]      nslot;
    logic [CNT_W-1:0]   base_nx;

    assign out_free    = !r_valid || i_res_ready;
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    // classification against the current window
    assign below  = i_q_frame.seq < r_base;
    assign in_win = !below &&
                    ({1'b0, i_q_frame.seq} < ({1'b0, r_base} + (CNT_W+1)'(WINDOW)));
    assign accept = !i_q_frame.beyond && in_win;

    // slot = (seq mod W) = base slot + (seq - base), wrapped once
    assign off   = i_q_frame.seq - r_base;
    assign sum   = {1'b0, r_bslot} + {1'b0, off[IW-1:0]};
    assign wslot = (sum >= (IW+1)'(WINDOW)) ? IW'(sum - (IW+1)'(WINDOW)) : sum[IW-1:0];

    assign nslot   = (r_bslot == LAST_SLOT) ? '0 : IW'(r_bslot + 1'b1);
    assign base_nx = CNT_W'(r_base + 1'b1);

    always_comb begin
        n_state = r_state;
        n_base  = r_base;
        n_bslot = r_bslot;
        n_marks = r_marks;
        n_valid = r_valid && !i_res_ready;
        n_res   = r_res;
        o_q_pop = 1'b0;
        we      = 1'b0;
        more    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_q_pop = 1'b1;
                    we      = accept;
                    if (accept) n_marks[wslot] = 1'b1;
                    more = accept && (r_base < i_total) &&
                           (r_marks[r_bslot] || (wslot == r_bslot));
                    n_valid        = 1'b1;
                    n_res.kind     = i_q_frame.beyond ? KIND_DROP :
                                     in_win           ? KIND_ACK  :
                                     below            ? KIND_DUP  : KIND_DROP;
                    n_res.seq      = i_q_frame.seq;
                    n_res.data     = '0;
                    n_res.last     = !more;
                    n_res.complete = (r_base >= i_total);
                    n_state        = more ? S_SLIDE : S_IDLE;
                end
            end
            S_SLIDE: begin
                // entered only when the base slot is known to be marked
                if (out_free) begin
                    n_marks[r_bslot] = 1'b0;
                    n_base           = base_nx;
                    n_bslot          = nslot;
                    more = (base_nx < i_total) && r_marks[nslot] && (nslot != r_bslot);
                    n_valid        = 1'b1;
                    n_res.kind     = KIND_DATA;
                    n_res.seq      = r_base;
                    n_res.data     = r_rd;
                    n_res.last     = !more;
                    n_res.complete = (base_nx >= i_total);
                    n_state        = more ? S_SLIDE : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_base  <= '0;
            r_bslot <= '0;
            r_marks <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_base  <= n_base;
            r_bslot <= n_bslot;
            r_marks <= n_marks;
            r_valid <= n_valid;
        end
        r_res <= n_res;
    end

    // slot store; read port follows the next base slot, write bypassed
    always_ff @(posedge i_clk) begin
        if (we) r_mem[wslot] <= i_q_frame.data;
        r_rd <= (we && (wslot == n_bslot)) ? i_q_frame.data : r_mem[n_bslot];
    end

endmodule

// ----- hdl/selective_repeat_receiver_core.sv -----
// Channel   Dir  Handshake          Payload
// s (in)    in   i_s_tvalid/o_s_tready  i_s_tdata: frame_seq, frame_data
// m (out)   out  o_m_tvalid/i_m_tready  o_m_tdata: out_seq, out_data, complete;
//                                       o_m_tuser: kind; o_m_tlast: last
// cfg       in   APB psel/penable       total_items at byte address 0
//
// Each frame yields one ack/dup/discard item, then up to WINDOW in-order
// data items when the window slides. The back end emits one item per cycle
// unless the output stalls, and a frame with no delivery then sustains one
// per cycle. A 2-entry frame queue lets input run ahead of the slide.
// Reset is synchronous, active low: base 0, all slot marks clear,
// total_items 16. Output stalls back up through the queue to o_s_tready.
module selective_repeat_receiver_core
    import srr_pkg::*;
#(
    parameter int WINDOW   = 8,
    parameter int SEQ_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input frames
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // [15:0] frame_seq, [47:16] frame_data
    // results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [15:0] out_seq, [47:16] out_data,
                                     // [48] complete, [55:49] zero
    output logic [1:0]  o_m_tuser,   // [1:0] kind
    output logic        o_m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_total;

    logic    q_valid;
    logic    q_pop;
    t_frame  q_frame;
    logic    res_valid;
    t_result res;

    // --- config register: word index in paddr[2], byte bits ignored
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOTAL_ITEMS) ? {16'd0, r_total} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= TOTAL_ITEMS_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_TOTAL_ITEMS)) begin
            r_total <= pwdata[CNT_W-1:0];
        end
    end

    // --- front: mask seq, tag frames past the transfer, queue them
    srr_front #(
        .SEQ_BITS (SEQ_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_total   (r_total),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_seq     (i_s_tdata[15:0]),
        .i_data    (i_s_tdata[47:16]),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_frame (q_frame)
    );

    // --- back: window check, slot store, slide and deliver
    srr_back #(
        .WINDOW (WINDOW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_total     (r_total),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_frame   (q_frame),
        .o_res_valid (res_valid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tvalid = res_valid;
    assign o_m_tdata  = {7'd0, res.complete, res.data, res.seq};
    assign o_m_tuser  = res.kind;
    assign o_m_tlast  = res.last;

endmodule
